FILE: design/sht_pkg.sv
// Shared types and constants of the string hashed slot table.
`timescale 1ns / 1ps
`default_nettype none

package sht_pkg;

    // Fixed widths of the item fields and of the registers.
    localparam int HASH_W      = 64;
    localparam int VALUE_OUT_W = 64;
    localparam int SLOT_W      = 9;
    localparam int INDEX_W     = 8;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_IDX_W   = 1;

    // Remainder unit: bits of the dividend consumed per cycle, and steps per item.
    localparam int REM_BITS  = 4;
    localparam int REM_STEPS = HASH_W / REM_BITS;
    localparam int REM_CNT_W = $clog2(REM_STEPS);

    // Operation codes carried in the mode field.
    localparam logic [1:0] MODE_SET  = 2'd0;
    localparam logic [1:0] MODE_GET  = 2'd1;
    localparam logic [1:0] MODE_FILL = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTER_MODE = 1'd1;

    localparam logic [SLOT_W-1:0] SLOT_COUNT_RESET = 9'd256;

    typedef struct packed {
        logic [1:0]             mode;
        logic [7:0]             name_byte;
        logic                   name_last;
        logic [VALUE_OUT_W-1:0] write_value;
    } t_in_item;

    typedef struct packed {
        logic                   ok;
        logic [VALUE_OUT_W-1:0] read_value;
        logic [INDEX_W-1:0]     slot_index;
    } t_out_item;

    // Request to the remainder unit.
    typedef struct packed {
        logic              start;
        logic [HASH_W-1:0] dividend;
        logic [SLOT_W-1:0] divisor;
    } t_rem_req;

    // Answer of the remainder unit; done is a one-cycle pulse.
    typedef struct packed {
        logic              done;
        logic [SLOT_W-1:0] rem;
    } t_rem_rsp;

endpackage

`default_nettype wire

FILE: design/sht_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module sht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: design/sht_rem_unit.sv
// Iterative remainder unit: hash modulo slot count, four dividend bits per cycle.
`timescale 1ns / 1ps
`default_nettype none

module sht_rem_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sht_pkg::t_rem_req i_req,
    output sht_pkg::t_rem_rsp      o_rsp
);

    import sht_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [REM_CNT_W-1:0] r_cnt, n_cnt;
    logic [HASH_W-1:0]    r_dvd, n_dvd;
    logic [SLOT_W-1:0]    r_div, n_div;
    logic [SLOT_W-1:0]    r_rem, n_rem;

    logic [HASH_W-1:0] step_dvd;
    logic [SLOT_W-1:0] step_rem;

    // Restoring remainder over REM_BITS dividend bits; the partial remainder
    // stays below the divisor, so one compare and subtract per bit suffices.
    always_comb begin
        logic [SLOT_W:0] t;
        step_dvd = r_dvd;
        step_rem = r_rem;
        for (int k = 0; k < REM_BITS; k++) begin
            t        = {step_rem, step_dvd[HASH_W-1]};
            step_dvd = {step_dvd[HASH_W-2:0], 1'b0};
            if (t >= {1'b0, r_div}) begin
                t = t - {1'b0, r_div};
            end
            step_rem = t[SLOT_W-1:0];
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_div  = r_div;
        n_rem  = r_rem;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_dvd  = i_req.dividend;
            n_div  = i_req.divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            n_dvd = step_dvd;
            n_rem = step_rem;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == REM_CNT_W'(REM_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_div <= n_div;
        r_rem <= n_rem;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

FILE: design/string_hashed_slot_table.sv
// Top level of the string hashed slot table.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps a direct-mapped table of TABLE_DEPTH values, each
// VALUE_WIDTH bits wide, addressed by a polynomial hash of a name that arrives
// one byte per item. For every item whose name_last is clear, the running
// hash becomes hash * 97 + byte (wrapping at 64 bits, zero bytes ignored) and
// the block is ready again at once. The item marked last starts the
// operation: the hash is reduced modulo the slot count in use by a remainder
// unit that consumes four hash bits per cycle; once the slot is known, a set
// writes the slot, a get reads it through the table memory's registered read
// port, and a fill writes every slot in use, one slot per cycle through the
// single write port. One result item follows every last item; it is held in
// an output register, so the bytes of the next name are accepted while it
// waits to be taken. A slot count of zero is treated as one and a count above
// TABLE_DEPTH as TABLE_DEPTH. After reset the block clears the whole table,
// one entry a cycle, and stalls its input during that time; configuration
// writes are taken at any time but should only be made while the block is
// idle.
module string_hashed_slot_table #(
    parameter int TABLE_DEPTH = 256,
    parameter int VALUE_WIDTH = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Input items
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire sht_pkg::t_in_item                 i_in_item,
    // Result items
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output sht_pkg::t_out_item                     o_out_item,
    // Configuration writes
    input  wire logic                              i_cfg_we,
    input  wire logic [sht_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [sht_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    import sht_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    // The slot count register cannot exceed its own range, so the clamp is
    // the smaller of the table depth and the largest register value.
    localparam int CAP_INT = (TABLE_DEPTH > (2 ** SLOT_W) - 1) ? (2 ** SLOT_W) - 1
                                                                : TABLE_DEPTH;
    localparam logic [SLOT_W-1:0] CNT_CAP   = SLOT_W'(CAP_INT);
    localparam logic [AW-1:0]     LAST_ADDR = AW'(TABLE_DEPTH - 1);

    // Sequencer states.
    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_OP     = 3'd3;
    localparam logic [2:0] S_READ   = 3'd4;
    localparam logic [2:0] S_FILL   = 3'd5;
    localparam logic [2:0] S_RESULT = 3'd6;

    // A slot number is always below the table depth, so it fits the address.
    function automatic logic [AW-1:0] addr_of(input logic [SLOT_W-1:0] slot);
        logic [AW+SLOT_W-1:0] ext;
        ext = {{AW{1'b0}}, slot};
        return ext[AW-1:0];
    endfunction

    logic [2:0]             r_state, n_state;
    logic [HASH_W-1:0]      r_hash, n_hash;
    logic [SLOT_W-1:0]      r_slot_count, n_slot_count;
    logic                   r_ptr_mode, n_ptr_mode;
    logic [AW-1:0]          r_sweep, n_sweep;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out_item, n_out_item;
    logic [1:0]             r_mode, n_mode;
    logic [VALUE_WIDTH-1:0] r_wval, n_wval;
    logic [SLOT_W-1:0]      r_slot, n_slot;
    logic [AW-1:0]          r_sweep_end, n_sweep_end;
    t_out_item              r_res, n_res;

    logic                           in_acc;
    logic                           out_free;
    logic [HASH_W-1:0]              hash_step;
    logic [SLOT_W-1:0]              eff_count;
    logic [VALUE_WIDTH+VALUE_OUT_W-1:0] rd_ext;
    logic [VALUE_OUT_W-1:0]         rd_wide;

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [VALUE_WIDTH-1:0] mem_wdata;
    logic                   mem_re;
    logic [VALUE_WIDTH-1:0] mem_rdata;

    t_rem_req rem_req;
    t_rem_rsp rem_rsp;

    // Items are taken only while no operation is in progress.
    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // 97 is 64 + 32 + 1, so the multiply reduces to two shifts and adds.
    always_comb begin
        if (i_in_item.name_byte != 8'd0) begin
            hash_step = (r_hash << 6) + (r_hash << 5) + r_hash
                        + HASH_W'(i_in_item.name_byte);
        end else begin
            hash_step = r_hash;
        end
    end

    always_comb begin
        if (r_slot_count == '0) begin
            eff_count = SLOT_W'(1);
        end else if (r_slot_count > CNT_CAP) begin
            eff_count = CNT_CAP;
        end else begin
            eff_count = r_slot_count;
        end
    end

    // Stored values are VALUE_WIDTH bits and read back zero-extended.
    assign rd_ext  = {{VALUE_OUT_W{1'b0}}, mem_rdata};
    assign rd_wide = rd_ext[VALUE_OUT_W-1:0];

    // The last byte's updated hash goes straight into the remainder unit.
    assign rem_req.start    = in_acc && i_in_item.name_last;
    assign rem_req.dividend = hash_step;
    assign rem_req.divisor  = eff_count;

    always_comb begin
        n_state      = r_state;
        n_hash       = r_hash;
        n_slot_count = r_slot_count;
        n_ptr_mode   = r_ptr_mode;
        n_sweep      = r_sweep;
        n_out_valid  = r_out_valid;
        n_out_item   = r_out_item;
        n_mode       = r_mode;
        n_wval       = r_wval;
        n_slot       = r_slot;
        n_sweep_end  = r_sweep_end;
        n_res        = r_res;

        mem_we    = 1'b0;
        mem_waddr = r_sweep;
        mem_wdata = r_wval;
        mem_re    = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                // Post-reset sweep that zeroes the whole table.
                mem_we    = 1'b1;
                mem_wdata = '0;
                if (r_sweep == LAST_ADDR) begin
                    n_sweep = '0;
                    n_state = S_IDLE;
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_item.name_last) begin
                        n_hash  = '0;
                        n_mode  = i_in_item.mode;
                        n_wval  = i_in_item.write_value[VALUE_WIDTH-1:0];
                        n_state = S_DIV;
                    end else begin
                        n_hash = hash_step;
                    end
                end
            end
            S_DIV: begin
                if (rem_rsp.done) begin
                    n_slot  = rem_rsp.rem;
                    n_state = S_OP;
                end
            end
            S_OP: begin
                n_res = '0;
                unique case (r_mode)
                    MODE_SET: begin
                        mem_we    = 1'b1;
                        mem_waddr = addr_of(r_slot);
                        n_res.ok         = 1'b1;
                        n_res.slot_index = r_slot[INDEX_W-1:0];
                        n_state          = S_RESULT;
                    end
                    MODE_GET: begin
                        mem_re  = 1'b1;
                        n_state = S_READ;
                    end
                    MODE_FILL: begin
                        n_res.ok    = 1'b1;
                        n_sweep     = '0;
                        n_sweep_end = addr_of(eff_count - 1'b1);
                        n_state     = S_FILL;
                    end
                    default: begin
                        // The unused code leaves the table alone and reports zeros.
                        n_state = S_RESULT;
                    end
                endcase
            end
            S_READ: begin
                n_res.ok         = r_ptr_mode ? (rd_wide != '0) : 1'b1;
                n_res.read_value = rd_wide;
                n_res.slot_index = r_slot[INDEX_W-1:0];
                n_state          = S_RESULT;
            end
            S_FILL: begin
                mem_we = 1'b1;
                if (r_sweep == r_sweep_end) begin
                    n_sweep = '0;
                    n_state = S_RESULT;
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_item  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SLOT_COUNT:   n_slot_count = i_cfg_data;
                CFG_POINTER_MODE: n_ptr_mode   = i_cfg_data[0];
                default:          n_slot_count = r_slot_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_hash       <= '0;
            r_slot_count <= SLOT_COUNT_RESET;
            r_ptr_mode   <= 1'b0;
            r_sweep      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_hash       <= n_hash;
            r_slot_count <= n_slot_count;
            r_ptr_mode   <= n_ptr_mode;
            r_sweep      <= n_sweep;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item  <= n_out_item;
        r_mode      <= n_mode;
        r_wval      <= n_wval;
        r_slot      <= n_slot;
        r_sweep_end <= n_sweep_end;
        r_res       <= n_res;
    end

    sht_rem_unit u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rem_req),
        .o_rsp   (rem_rsp)
    );

    sht_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (addr_of(r_slot)),
        .o_rdata (mem_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

FILE: design/sht_checker.sv
// Port-level checker of the string hashed slot table, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module sht_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire sht_pkg::t_in_item  i_in_item,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire sht_pkg::t_out_item o_out_item
);

    import sht_pkg::*;

    // A last byte starts an operation, so the input must stall next cycle.
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_item.name_last)
        |=> o_in_stall)
        else $error("input not stalled after a last item");

    // A plain name byte only updates the hash and the block stays ready.
    a_byte_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !i_in_item.name_last)
        |=> !o_in_stall)
        else $error("input stalled after a plain name byte");

    // A new result only comes out of an operation in progress.
    a_result_from_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without an operation in progress");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

endmodule

bind string_hashed_slot_table sht_checker u_sht_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire

FILE: verif/slot_table_checker.sv
// Checker for the string hashed slot table: predicts each result item and compares it.
`timescale 1ns / 1ps

module slot_table_checker #(
    parameter int TABLE_DEPTH = 256,
    parameter int VALUE_WIDTH = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_stall,
    input  wire sht_pkg::t_in_item              i_in_item,
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_stall,
    input  wire sht_pkg::t_out_item             i_out_item,
    input  wire logic                           i_cfg_we,
    input  wire logic [sht_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [sht_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_results_checked
);
    import sht_pkg::*;

    localparam logic [63:0] VALUE_MASK =
        (VALUE_WIDTH >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << VALUE_WIDTH) - 64'd1);

    logic [HASH_W-1:0]      name_hash;
    logic [63:0]            slot_model [TABLE_DEPTH];
    logic [SLOT_W-1:0]      slot_count_reg;
    logic                   pointer_mode_reg;
    t_out_item              awaited_results [$];
    int                     fail_total;
    int                     checked_total;

    initial begin
        o_fail_count      = 0;
        o_pending         = 0;
        o_results_checked = 0;
        fail_total        = 0;
        checked_total     = 0;
    end

    // Out-of-range counts are clamped the same way the block does.
    function automatic int unsigned slots_in_use();
        if (slot_count_reg == '0) return 1;
        if (slot_count_reg > TABLE_DEPTH) return TABLE_DEPTH;
        return slot_count_reg;
    endfunction

    task automatic fold_name_item(input t_in_item it);
        logic [63:0]       wval;
        logic [63:0]       stored;
        logic [SLOT_W-1:0] slot;
        int unsigned       used;
        t_out_item         res;
        if (it.name_byte != 8'd0) begin
            name_hash = name_hash * 64'd97 + {56'd0, it.name_byte};
        end
        if (!it.name_last) return;
        used      = slots_in_use();
        slot      = SLOT_W'(name_hash % used);
        name_hash = '0;
        res       = '0;
        wval      = it.write_value & VALUE_MASK;
        case (it.mode)
            MODE_SET: begin
                slot_model[slot] = wval;
                res.ok           = 1'b1;
                res.slot_index   = slot[INDEX_W-1:0];
            end
            MODE_GET: begin
                stored         = slot_model[slot];
                res.ok         = pointer_mode_reg ? (stored != 64'd0) : 1'b1;
                res.read_value = stored;
                res.slot_index = slot[INDEX_W-1:0];
            end
            MODE_FILL: begin
                for (int i = 0; i < used; i++) slot_model[i] = wval;
                res.ok = 1'b1;
            end
            default: ;
        endcase
        awaited_results.push_back(res);
    endtask

    task automatic compare_result(input t_out_item got);
        t_out_item want;
        if (awaited_results.size() == 0) begin
            $error("slot table: result item with none awaited (read_value %0h)", got.read_value);
            fail_total++;
            return;
        end
        want = awaited_results.pop_front();
        checked_total++;
        if (got.ok !== want.ok) begin
            $error("slot table: ok expected %0h actual %0h", want.ok, got.ok);
            fail_total++;
        end
        if (got.read_value !== want.read_value) begin
            $error("slot table: read_value expected %0h actual %0h",
                   want.read_value, got.read_value);
            fail_total++;
        end
        if (got.slot_index !== want.slot_index) begin
            $error("slot table: slot_index expected %0h actual %0h",
                   want.slot_index, got.slot_index);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            name_hash        = '0;
            slot_count_reg   = SLOT_COUNT_RESET;
            pointer_mode_reg = 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++) slot_model[i] = '0;
            awaited_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) compare_result(i_out_item);
            if (i_in_valid && !i_in_stall) fold_name_item(i_in_item);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SLOT_COUNT:   slot_count_reg   = i_cfg_data[SLOT_W-1:0];
                    CFG_POINTER_MODE: pointer_mode_reg = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        o_pending         <= awaited_results.size();
        o_fail_count      <= fail_total;
        o_results_checked <= checked_total;
    end

endmodule

FILE: verif/tb.sv
// Testbench top for the string hashed slot table: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb;
    import sht_pkg::*;

    localparam int TABLE_DEPTH   = 256;
    localparam int VALUE_WIDTH   = 64;
    localparam int NAME_MAX      = 16;
    localparam int POOL_SIZE     = 12;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int PHASES        = 10;
    // Settle time allowed once every awaited result is in, before a register
    // write and before the verdict.
    localparam int DRAIN_CYCLES  = 32;
    // Worst correct run: about 2050 items, each a fill of all 256 slots behind
    // the longest input gap and result stall, plus the clearing pass after
    // reset. The limit is several times that.
    localparam int RUN_LIMIT     = 4_000_000;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    t_in_item          in_item     = '0;
    logic              out_stall   = 1'b0;
    logic              cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic              in_stall;
    logic              out_valid;
    t_out_item         out_item;

    int                fail_count;
    int                pending;
    int                results_checked;

    // Idling is switched off for whole phases now and then, so that long
    // back-to-back stretches are seen as well as ragged ones.
    logic              idle_on     = 1'b1;
    int                stall_left  = 0;
    int unsigned       cycle_count = 0;

    int                items_sent  = 0;
    int                names_by_op [4];
    logic [7:0]        name_buf [NAME_MAX];
    logic [7:0]        pool_bytes [POOL_SIZE][NAME_MAX];
    int                pool_len [POOL_SIZE];

    initial forever #1 clk = ~clk;

    string_hashed_slot_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    slot_table_checker #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) table_monitor (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_in_item         (in_item),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_out_item        (out_item),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_results_checked (results_checked)
    );

    // The result side stalls in bursts; now and then a burst is a long hold
    // that backs the block up into its input.
    always @(posedge clk) begin
        if (stall_left != 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 99) < 25) begin
            out_stall  <= 1'b1;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 2);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Guard against a hang anywhere in the run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("string_hashed_slot_table verification failed");
            $finish;
        end
    end

    // Gap in front of an input item: usually none, often short, rarely long.
    function automatic int input_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Zero bytes are given extra weight since the hash skips them.
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 9) == 0) return 8'd0;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [63:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 64'd0;
        if (r == 1) return 64'hFFFF_FFFF_FFFF_FFFF;
        return {$urandom, $urandom};
    endfunction

    // Sets and gets dominate; fills are kept rare because each one walks
    // every slot in use.
    function automatic logic [1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return MODE_SET;
        if (r < 85) return MODE_GET;
        if (r < 93) return MODE_FILL;
        return MODE_NONE;
    endfunction

    // Called just after a rising edge. The item is held until the edge at
    // which the block does not stall it; valid stays high into the next item
    // unless a gap is drawn.
    task automatic send_item(input t_in_item it);
        int gap;
        gap = input_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    // Sends the first len bytes of name_buf as one name. Mode and value on
    // the bytes before the last are ignored by the block, so they carry noise.
    task automatic send_name(input int len, input logic [1:0] op, input logic [63:0] value);
        t_in_item it;
        for (int k = 0; k < len; k++) begin
            it.name_byte = name_buf[k];
            it.name_last = (k == len - 1);
            it.mode        = it.name_last ? op : 2'($urandom_range(0, 3));
            it.write_value = it.name_last ? value : {$urandom, $urandom};
            send_item(it);
        end
        names_by_op[op]++;
    endtask

    // Most names come from a small pool so that gets find what sets left;
    // the rest are fresh, a few of them long enough to wrap the hash.
    task automatic make_name(output int len);
        int idx;
        if ($urandom_range(0, 9) < 7) begin
            idx = $urandom_range(0, POOL_SIZE - 1);
            len = pool_len[idx];
            for (int k = 0; k < len; k++) name_buf[k] = pool_bytes[idx][k];
        end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, NAME_MAX)
                                              : $urandom_range(1, 6);
            for (int k = 0; k < len; k++) name_buf[k] = pick_byte();
        end
    endtask

    // Lets every awaited result arrive, then gives the block time to settle.
    // The first edge lets the checker's count catch up with the last item.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes both registers on consecutive edges; the spare data bits of the
    // pointer mode write carry random content.
    task automatic configure(input logic [SLOT_W-1:0] slots, input logic pmode);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SLOT_COUNT;
        cfg_data  <= slots;
        @(posedge clk);
        cfg_index <= CFG_POINTER_MODE;
        cfg_data  <= {8'($urandom_range(0, 255)), pmode};
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        int                len;
        int                phase_start;
        logic [SLOT_W-1:0] slots;
        logic              pmode;

        foreach (names_by_op[i]) names_by_op[i] = 0;
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_len[i] = (i < 2) ? $urandom_range(10, 14) : $urandom_range(1, 5);
            for (int k = 0; k < NAME_MAX; k++) pool_bytes[i][k] = pick_byte();
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset settings: a name of one zero byte lands
        // on slot zero, extreme bytes and values, a long name whose hash
        // wraps, the unused mode leaving the store alone, and a fill seen
        // through a later get.
        idle_on <= 1'b0;
        name_buf[0] = 8'h00;
        send_name(1, MODE_GET, 64'hFFFF_FFFF_FFFF_FFFF);
        name_buf[0] = 8'hFF;
        send_name(1, MODE_SET, 64'hFFFF_FFFF_FFFF_FFFF);
        send_name(1, MODE_GET, 64'd0);
        for (int k = 0; k < 10; k++) name_buf[k] = 8'hFF;
        send_name(10, MODE_SET, 64'd0);
        name_buf[0] = 8'h01;
        send_name(1, MODE_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_name(1, MODE_GET, 64'd0);
        name_buf[0] = 8'h80;
        send_name(1, MODE_FILL, 64'h5A5A_A5A5_0F0F_F0F0);
        name_buf[0] = 8'hFF;
        send_name(1, MODE_GET, 64'd0);

        // A zero slot count acts as one slot; in pointer mode a get of a zero
        // entry reports failure and of a nonzero one success.
        wait_idle();
        configure(9'd0, 1'b1);
        name_buf[0] = 8'h10;
        send_name(1, MODE_SET, 64'd0);
        name_buf[0] = 8'h20;
        send_name(1, MODE_GET, 64'd0);
        send_name(1, MODE_SET, 64'hFFFF_FFFF_FFFF_FFFF);
        send_name(1, MODE_GET, 64'd0);

        // Random phases, each at its own register setting: one slot, the full
        // table, counts above the table depth, an odd count, two slots, then random ones.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       begin slots = 9'd1;   pmode = 1'b0; end
                1:       begin slots = 9'd256; pmode = 1'b1; end
                2:       begin slots = 9'd511; pmode = 1'b0; end
                3:       begin slots = 9'd257; pmode = 1'b1; end
                4:       begin slots = 9'd97;  pmode = 1'b0; end
                5:       begin slots = 9'd2;   pmode = 1'b1; end
                default: begin
                    slots = 9'($urandom_range(0, 511));
                    pmode = 1'($urandom_range(0, 1));
                end
            endcase
            wait_idle();
            configure(slots, pmode);
            idle_on     <= ($urandom_range(0, 3) != 0);
            phase_start = items_sent;
            while (items_sent - phase_start < RANDOM_ITEMS / PHASES) begin
                make_name(len);
                send_name(len, pick_op(), pick_value());
            end
        end

        wait_idle();
        $display("Sent %0d input items over %0d register settings; %0d results compared.",
                 items_sent, PHASES + 2, results_checked);
        $display("Names by operation: %0d set, %0d get, %0d fill, %0d unused mode.",
                 names_by_op[MODE_SET], names_by_op[MODE_GET],
                 names_by_op[MODE_FILL], names_by_op[MODE_NONE]);
        if (fail_count == 0 && pending == 0) begin
            $display("string_hashed_slot_table verification clean");
        end else begin
            $display("string_hashed_slot_table verification failed");
        end
        $finish;
    end

endmodule
